// File: hdl/reciprocating_step_pulse_generator_defines.svh
// Assertion helpers shared by the step generator modules.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef RECIPROCATING_STEP_PULSE_GENERATOR_DEFINES_SVH
`define RECIPROCATING_STEP_PULSE_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSPG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rspg_pkg.sv
`default_nettype none

package rspg_pkg;

    // Default scaling of the motion.
    localparam int SPU_DEFAULT         = 100;
    localparam int DELAY_SCALE_DEFAULT = 100;

    // Settings are three decimal digits.
    localparam int SET_W       = 10;
    localparam int MAX_SETTING = 999;
    localparam logic [SET_W-1:0] SPEED_RESET  = SET_W'(100);
    localparam logic [SET_W-1:0] STROKE_RESET = SET_W'(50);

    // Command framing.
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] CMD_LAST_IDX = IDX_W'(6);

    // ASCII codes.
    localparam logic [7:0] CH_QUIT    = 8'h71;
    localparam logic [7:0] CH_NEG_UP  = 8'h4E;
    localparam logic [7:0] CH_NEG_LOW = 8'h6E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic out_load;
        logic parse;
        logic scale;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cmd_last;
        logic div_busy;
        logic out_valid;
    } t_dp_sts;

    typedef struct packed {
        logic             ok;
        logic [SET_W-1:0] val;
    } t_digits;

    // Decode three ASCII digits into a value; ok is low if any is not a digit.
    function automatic t_digits f_three_digits(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        t_digits    res;
        logic [7:0] da;
        logic [7:0] db;
        logic [7:0] dc;
        da      = a - CH_ZERO;
        db      = b - CH_ZERO;
        dc      = c - CH_ZERO;
        res.ok  = (a >= CH_ZERO) && (a <= CH_NINE) && (b >= CH_ZERO) && (b <= CH_NINE)
                  && (c >= CH_ZERO) && (c <= CH_NINE);
        res.val = SET_W'(da[3:0]) * SET_W'(100) + SET_W'(db[3:0]) * SET_W'(10)
                  + SET_W'(dc[3:0]);
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hdl/reciprocating_step_pulse_generator.sv
// Reciprocating step/direction generator. Each request is either a 1 ms tick
// (i_mode low) or a received command byte (i_mode high), and each gives one
// result. A tick or an ordinary byte loads its result when it is accepted.
// For the seventh byte of a command, the digits are decoded, the half stroke
// is scaled, and a bit-serial divider works out the step spacing
// DELAY_SCALE / speed, one quotient bit per cycle, before motion starts.
// A single result register lets a new request in while the previous result
// is being taken; a stalled result holds back the next request.
`default_nettype none

module reciprocating_step_pulse_generator #(
    parameter int STEPS_PER_UNIT = rspg_pkg::SPU_DEFAULT,
    parameter int DELAY_SCALE    = rspg_pkg::DELAY_SCALE_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_mode,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_pulse_forward,
    output logic            o_pulse_reverse,
    output logic            o_direction_level,
    output logic            o_prompt_out,
    output logic            o_running
);
    import rspg_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer for requests and the command start-up.
    rspg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Settings, position, spacing and the result register.
    rspg_dp #(
        .STEPS_PER_UNIT (STEPS_PER_UNIT),
        .DELAY_SCALE    (DELAY_SCALE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mode            (i_mode),
        .i_rx_byte         (i_rx_byte),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_pulse_forward   (o_pulse_forward),
        .o_pulse_reverse   (o_pulse_reverse),
        .o_direction_level (o_direction_level),
        .o_prompt_out      (o_prompt_out),
        .o_running         (o_running)
    );

endmodule

`default_nettype wire

// File: hdl/rspg_div.sv
`default_nettype none

module rspg_div #(
    parameter int DW = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [DW-1:0]            i_dividend,
    input  wire logic [rspg_pkg::SET_W-1:0] i_divisor,
    output logic                          o_busy,
    output logic [DW-1:0]                 o_quotient
);
    import rspg_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic [DW-1:0]    r_quo;
    logic [DW-1:0]    n_quo;
    logic [SET_W-1:0] r_rem;
    logic [SET_W-1:0] n_rem;
    logic [SET_W-1:0] r_dvs;
    logic [SET_W-1:0] n_dvs;
    logic [SET_W:0]   rem_sh;
    logic             ge;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        rem_sh = {r_rem, r_quo[DW-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_cnt = CW'(DW);
            n_quo = i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CW'(1);
            n_quo = DW'({r_quo, ge});
            n_rem = ge ? SET_W'(rem_sh - {1'b0, r_dvs}) : SET_W'(rem_sh);
        end
    end

    // Iteration count is control state; the operands are not reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: hdl/rspg_dp.sv
`default_nettype none
`include "reciprocating_step_pulse_generator_defines.svh"

module rspg_dp #(
    parameter int STEPS_PER_UNIT = 100,
    parameter int DELAY_SCALE    = 100
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rspg_pkg::t_dp_cmd i_cmd,
    output rspg_pkg::t_dp_sts      o_sts,
    input  wire logic              i_mode,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic                   o_pulse_forward,
    output logic                   o_pulse_reverse,
    output logic                   o_direction_level,
    output logic                   o_prompt_out,
    output logic                   o_running
);
    import rspg_pkg::*;

    localparam int HALF_W = $clog2(MAX_SETTING * STEPS_PER_UNIT + 1);
    localparam int POS_W  = HALF_W + 1;
    localparam int DW     = $clog2(DELAY_SCALE + 1);

    // Settings and motion state.
    logic              r_running;
    logic              n_running;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [7:0]        r_buf [0:6];
    logic [SET_W-1:0]  r_speed;
    logic [SET_W-1:0]  n_speed;
    logic [SET_W-1:0]  r_stroke;
    logic [SET_W-1:0]  n_stroke;
    logic [HALF_W-1:0] r_half;
    logic [HALF_W-1:0] n_half;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [DW-1:0]     r_delay;
    logic [DW-1:0]     n_delay;
    logic [DW-1:0]     r_interval_m1;
    logic [DW-1:0]     n_interval_m1;
    logic              r_dir;
    logic              n_dir;

    // Output register.
    logic              r_out_valid;
    logic              r_fwd;
    logic              r_rev;
    logic              r_dir_out;
    logic              r_prompt;
    logic              r_run_out;

    logic              fwd;
    logic              rev;
    logic              prompt;
    logic [POS_W-1:0]  two_half;
    logic [POS_W-1:0]  pos_inc;
    logic              negative;
    logic              div_busy;
    logic [DW-1:0]     quotient;
    t_digits           speed_dig;
    t_digits           stroke_dig;

    // Step spacing divider, run once per command.
    rspg_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.scale),
        .i_dividend (DW'(DELAY_SCALE)),
        .i_divisor  (r_speed),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign two_half   = {r_half, 1'b0};
    assign pos_inc    = r_pos + POS_W'(1);
    assign negative   = (r_buf[0] == CH_NEG_UP) || (r_buf[0] == CH_NEG_LOW);
    assign speed_dig  = f_three_digits(r_buf[1], r_buf[2], r_buf[3]);
    assign stroke_dig = f_three_digits(r_buf[4], r_buf[5], r_buf[6]);

    // Item handling and the command sequence steps.
    always_comb begin
        n_running     = r_running;
        n_idx         = r_idx;
        n_speed       = r_speed;
        n_stroke      = r_stroke;
        n_half        = r_half;
        n_pos         = r_pos;
        n_delay       = r_delay;
        n_interval_m1 = r_interval_m1;
        n_dir         = r_dir;
        fwd           = 1'b0;
        rev           = 1'b0;
        prompt        = 1'b0;
        if (i_cmd.accept) begin
            if (i_mode) begin
                if (r_running) begin
                    if (i_rx_byte == CH_QUIT) begin
                        n_running = 1'b0;
                        n_idx     = '0;
                        n_dir     = 1'b0;
                        prompt    = 1'b1;
                    end
                end else begin
                    n_idx = (r_idx == CMD_LAST_IDX) ? '0 : r_idx + IDX_W'(1);
                end
            end else if (r_running) begin
                if (r_speed == '0) begin
                    n_dir = 1'b0;
                end else if (r_half != '0) begin
                    if (r_delay == '0) begin
                        fwd     = r_pos < POS_W'(r_half);
                        rev     = !fwd;
                        n_dir   = fwd;
                        n_pos   = (pos_inc >= two_half) ? '0 : pos_inc;
                        n_delay = r_interval_m1;
                    end else begin
                        n_delay = r_delay - DW'(1);
                    end
                end
            end
        end
        if (i_cmd.parse) begin
            if (speed_dig.ok) begin
                n_speed = speed_dig.val;
            end
            if (stroke_dig.ok) begin
                n_stroke = stroke_dig.val;
            end
        end
        if (i_cmd.scale) begin
            n_half = HALF_W'(32'(r_stroke) * 32'(STEPS_PER_UNIT));
        end
        if (i_cmd.finish) begin
            n_pos         = negative ? POS_W'(r_half) : '0;
            n_delay       = '0;
            n_running     = 1'b1;
            n_interval_m1 = (quotient == '0) ? '0 : quotient - DW'(1);
        end
    end

    // Motion state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_idx     <= '0;
            r_speed   <= SPEED_RESET;
            r_stroke  <= STROKE_RESET;
            r_pos     <= '0;
            r_delay   <= '0;
            r_dir     <= 1'b0;
        end else begin
            r_running <= n_running;
            r_idx     <= n_idx;
            r_speed   <= n_speed;
            r_stroke  <= n_stroke;
            r_pos     <= n_pos;
            r_delay   <= n_delay;
            r_dir     <= n_dir;
        end
        r_half        <= n_half;
        r_interval_m1 <= n_interval_m1;
    end

    // Command byte buffer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_mode && !r_running) begin
            r_buf[r_idx] <= i_rx_byte;
        end
    end

    // Result register; requests fill it only when empty or draining, the finish load does not check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_fwd     <= fwd;
            r_rev     <= rev;
            r_dir_out <= n_dir;
            r_prompt  <= prompt;
            r_run_out <= n_running;
        end
    end

    assign o_sts.cmd_last  = i_mode && !r_running && (r_idx == CMD_LAST_IDX);
    assign o_sts.div_busy  = div_busy;
    assign o_sts.out_valid = r_out_valid;

    assign o_out_valid       = r_out_valid;
    assign o_pulse_forward   = r_fwd;
    assign o_pulse_reverse   = r_rev;
    assign o_direction_level = r_dir_out;
    assign o_prompt_out      = r_prompt;
    assign o_running         = r_run_out;

    `RSPG_ASSERT_SAME(a_pos_in_range, r_running && (r_half != '0), r_pos < two_half, "position left its stroke range")
    `RSPG_ASSERT_SAME(a_delay_bounded, r_running, r_delay <= r_interval_m1, "step delay exceeds spacing")
    `RSPG_ASSERT_SAME(a_one_pulse, r_out_valid, !(r_fwd && r_rev), "forward and reverse pulse together")

endmodule

`default_nettype wire

// File: hdl/rspg_ctrl.sv
`default_nettype none
`include "reciprocating_step_pulse_generator_defines.svh"

module rspg_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_out_stall,
    input  wire rspg_pkg::t_dp_sts i_sts,
    output rspg_pkg::t_dp_cmd      o_cmd
);
    import rspg_pkg::*;

    typedef enum logic [4:0] {
        ST_WAIT  = 5'b00001,
        ST_PARSE = 5'b00010,
        ST_SCALE = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // A request is taken only while waiting and with room in the result register.
    assign o_in_stall = (r_state != ST_WAIT) || (i_sts.out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    // Commands to the datapath.
    always_comb begin
        o_cmd.accept   = accept;
        o_cmd.out_load = (accept && !i_sts.cmd_last) || (r_state == ST_DONE);
        o_cmd.parse    = r_state == ST_PARSE;
        o_cmd.scale    = r_state == ST_SCALE;
        o_cmd.finish   = r_state == ST_DONE;
    end

    // The last command byte runs parse, scale, divide and start-up in turn.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_WAIT: begin
                if (accept && i_sts.cmd_last) begin
                    n_state = ST_PARSE;
                end
            end
            ST_PARSE: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_WAIT;
            end
            default: begin
                n_state = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

    `RSPG_ASSERT_NEXT(a_cmd_to_parse, accept && i_sts.cmd_last, r_state == ST_PARSE, "complete command did not start parsing")
    `RSPG_ASSERT_NEXT(a_div_to_done, (r_state == ST_DIV) && !i_sts.div_busy, r_state == ST_DONE, "divide end did not start motion")
    `RSPG_ASSERT_SAME(a_no_overwrite, o_cmd.out_load, !(i_sts.out_valid && i_out_stall), "result overwritten while stalled")

endmodule

`default_nettype wire
